>>> rtl/core/lap3_pkg.sv
// ----------------------------------------------------------------------------
// lap3_pkg
// shared constants, register codes and types of the 3x3 convolution filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lap3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W     = 8;
  localparam int MASK_W    = 24;
  localparam int FW_W      = 11;
  localparam int FH_W      = 13;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int H_W    = $clog2(MAX_HEIGHT + 1);
  localparam int LIN_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int CMP_W  = W_W + 1;
  localparam int RCMP_W = H_W + 1;
  localparam int THR_W  = LIN_W + 1;

  localparam logic [MASK_W-1:0] MASK_TOP_RST    = 24'd256;
  localparam logic [MASK_W-1:0] MASK_MIDDLE_RST = 24'd130049;
  localparam logic [MASK_W-1:0] MASK_BOTTOM_RST = 24'd256;
  localparam logic [FW_W-1:0]   FRAME_W_RST     = 11'd1024;
  localparam logic [FH_W-1:0]   FRAME_H_RST     = 13'd1024;

  localparam logic REQ_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASK_TOP     = 3'd0,
    CFG_MASK_MIDDLE  = 3'd1,
    CFG_MASK_BOTTOM  = 3'd2,
    CFG_FRAME_WIDTH  = 3'd3,
    CFG_FRAME_HEIGHT = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic             emit;
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
    logic             last;
    logic             single;
    logic             fwd;
    logic [PIX_W-1:0] bot;
    logic [PIX_W-1:0] single_mid;
  } s1_t;

  function automatic logic [W_W-1:0] eff_width(input logic [FW_W-1:0] fw);
    if (fw == '0) begin
      return W_W'(1);
    end else if (int'(fw) > MAX_WIDTH) begin
      return W_W'(MAX_WIDTH);
    end else begin
      return W_W'(fw);
    end
  endfunction

  function automatic logic [H_W-1:0] eff_height(input logic [FH_W-1:0] fh);
    if (fh == '0) begin
      return H_W'(1);
    end else if (int'(fh) > MAX_HEIGHT) begin
      return H_W'(MAX_HEIGHT);
    end else begin
      return H_W'(fh);
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/laplacian_3x3_convolution.sv
// ----------------------------------------------------------------------------
// laplacian_3x3_convolution
// 3x3 weighted-sum filter with zero padding over a raster-order pixel stream
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): one item per accepted cycle, either
// a pixel or a drain. Drains flush the results still pending at frame end and
// are dropped when nothing is pending. Each item gives zero or one result on
// the output channel (out_valid_o / out_stall_i), in order.
// Throughput: one item per cycle while in_stall_o is low. The column is read
// from the two line memories at the accepting edge, and the window and the
// nine products are evaluated from those registers into the output register
// once the window stage can move.
// A write of the frame width recomputes the linear positions with a
// multiplier and raises in_stall_o in the cycle after that write.
// Reset clears the counters, the window, the valid flags and the settings to
// their defaults; the line memories are not cleared and need no clearing pass.
// While the receiver stalls, the output register holds its result; items keep
// entering until the stage behind it holds a result as well, then in_stall_o
// rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module laplacian_3x3_convolution (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lap3_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lap3_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic [lap3_pkg::PIX_W-1:0]           pixel_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lap3_pkg::PIX_W-1:0]           pixel_out_o,
  output logic                                 frame_last_o
);

  // configuration
  logic [lap3_pkg::MASK_W-1:0] mask_top_q, mask_mid_q, mask_bot_q;
  logic [lap3_pkg::FW_W-1:0]   frame_w_q;
  logic [lap3_pkg::FH_W-1:0]   frame_h_q;
  logic                        recalc_q;

  // position state
  logic [lap3_pkg::COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [lap3_pkg::ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [lap3_pkg::LIN_W-1:0] in_lin_q, in_lin_d, out_lin_q, out_lin_d;
  logic                       flushing_q, flushing_d;

  logic [lap3_pkg::W_W-1:0]    w;
  logic [lap3_pkg::H_W-1:0]    h;
  logic [lap3_pkg::CMP_W-1:0]  in_c1, out_c1;
  logic [lap3_pkg::RCMP_W-1:0] in_r1, out_r1;
  logic                        in_col_end, out_col_end, in_row_end, out_row_end;
  logic [lap3_pkg::COL_W-1:0]  rc;
  logic [lap3_pkg::THR_W-1:0]  emit_thr;
  logic                        accept, is_pixel, act, pix_act, emit;
  logic [lap3_pkg::LIN_W-1:0]  in_calc, out_calc;

  // line memories and the pending copy into the upper row
  logic [lap3_pkg::PIX_W-1:0] low_mem  [lap3_pkg::MAX_WIDTH];
  logic [lap3_pkg::PIX_W-1:0] high_mem [lap3_pkg::MAX_WIDTH];
  logic [lap3_pkg::PIX_W-1:0] low_a_rd_q, low_b_rd_q, high_rd_q, fwd_data_q, low0_q;
  logic                       hw_pend_q;
  logic [lap3_pkg::COL_W-1:0] hw_addr_q;

  // window stage and output register
  lap3_pkg::s1_t              s1_q, s1_d;
  logic                       s1_valid_q, s1_valid_d, s1_move;
  logic [lap3_pkg::PIX_W-1:0] win_q [9];
  logic [lap3_pkg::PIX_W-1:0] nw    [9];
  logic [lap3_pkg::PIX_W-1:0] coef  [9];
  logic [lap3_pkg::PIX_W-1:0] col_top, col_mid, col_bot, sum;
  logic [2*lap3_pkg::PIX_W-1:0] prod;
  logic                       out_valid_q, out_valid_d;
  logic [lap3_pkg::PIX_W-1:0] pixel_out_q;
  logic                       frame_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_top_q <= lap3_pkg::MASK_TOP_RST;
      mask_mid_q <= lap3_pkg::MASK_MIDDLE_RST;
      mask_bot_q <= lap3_pkg::MASK_BOTTOM_RST;
      frame_w_q  <= lap3_pkg::FRAME_W_RST;
      frame_h_q  <= lap3_pkg::FRAME_H_RST;
      recalc_q   <= 1'b0;
    end else begin
      recalc_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (lap3_pkg::cfg_index_e'(cfg_index_i))
          lap3_pkg::CFG_MASK_TOP:     mask_top_q <= cfg_data_i;
          lap3_pkg::CFG_MASK_MIDDLE:  mask_mid_q <= cfg_data_i;
          lap3_pkg::CFG_MASK_BOTTOM:  mask_bot_q <= cfg_data_i;
          lap3_pkg::CFG_FRAME_WIDTH: begin
            frame_w_q <= cfg_data_i[lap3_pkg::FW_W-1:0];
            recalc_q  <= 1'b1;
          end
          lap3_pkg::CFG_FRAME_HEIGHT: frame_h_q <= cfg_data_i[lap3_pkg::FH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign w = lap3_pkg::eff_width(frame_w_q);
  assign h = lap3_pkg::eff_height(frame_h_q);

  assign in_c1       = lap3_pkg::CMP_W'(in_col_q) + lap3_pkg::CMP_W'(1);
  assign out_c1      = lap3_pkg::CMP_W'(out_col_q) + lap3_pkg::CMP_W'(1);
  assign in_r1       = lap3_pkg::RCMP_W'(in_row_q) + lap3_pkg::RCMP_W'(1);
  assign out_r1      = lap3_pkg::RCMP_W'(out_row_q) + lap3_pkg::RCMP_W'(1);
  assign in_col_end  = in_c1 >= lap3_pkg::CMP_W'(w);
  assign out_col_end = out_c1 >= lap3_pkg::CMP_W'(w);
  assign in_row_end  = in_r1 >= lap3_pkg::RCMP_W'(h);
  assign out_row_end = out_r1 >= lap3_pkg::RCMP_W'(h);

  assign in_calc  = lap3_pkg::LIN_W'(in_row_q) * lap3_pkg::LIN_W'(w)
                  + lap3_pkg::LIN_W'(in_col_q);
  assign out_calc = lap3_pkg::LIN_W'(out_row_q) * lap3_pkg::LIN_W'(w)
                  + lap3_pkg::LIN_W'(out_col_q);

  assign s1_move    = !s1_q.emit || !out_valid_q || !out_stall_i;
  assign in_stall_o = recalc_q || (s1_valid_q && !s1_move);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_pixel   = req_type_i != lap3_pkg::REQ_DRAIN;
  assign act        = accept && (is_pixel || flushing_q);
  assign pix_act    = accept && is_pixel;

  assign emit_thr = lap3_pkg::THR_W'(out_lin_q) + lap3_pkg::THR_W'(w)
                  + lap3_pkg::THR_W'(1);
  assign emit     = flushing_q
                  || (is_pixel && (lap3_pkg::THR_W'(in_lin_q) >= emit_thr));

  always_comb begin
    if (flushing_q) begin
      rc = out_col_end ? '0 : out_c1[lap3_pkg::COL_W-1:0];
    end else begin
      rc = in_col_q;
    end
  end

  // position update: centre emit first, then the input position
  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_lin_d   = in_lin_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_lin_d  = out_lin_q;
    flushing_d = flushing_q;
    if (recalc_q) begin
      in_lin_d  = in_calc;
      out_lin_d = out_calc;
    end
    if (act && emit) begin
      if (out_row_end && out_col_end) begin
        out_col_d  = '0;
        out_row_d  = '0;
        out_lin_d  = '0;
        flushing_d = 1'b0;
      end else if (out_col_end) begin
        out_col_d = '0;
        out_row_d = out_r1[lap3_pkg::ROW_W-1:0];
        out_lin_d = out_lin_q - lap3_pkg::LIN_W'(out_col_q) + lap3_pkg::LIN_W'(w);
      end else begin
        out_col_d = out_c1[lap3_pkg::COL_W-1:0];
        out_lin_d = out_lin_q + lap3_pkg::LIN_W'(1);
      end
    end
    if (pix_act) begin
      if (in_col_end) begin
        in_col_d = '0;
        if (in_row_end) begin
          in_row_d   = '0;
          in_lin_d   = '0;
          flushing_d = 1'b1;
        end else begin
          in_row_d = in_r1[lap3_pkg::ROW_W-1:0];
          in_lin_d = in_lin_q - lap3_pkg::LIN_W'(in_col_q) + lap3_pkg::LIN_W'(w);
        end
      end else begin
        in_col_d = in_c1[lap3_pkg::COL_W-1:0];
        in_lin_d = in_lin_q + lap3_pkg::LIN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_lin_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_lin_q  <= '0;
      flushing_q <= 1'b0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_lin_q   <= in_lin_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_lin_q  <= out_lin_d;
      flushing_q <= flushing_d;
    end
  end

  // row above the input row, read before the write of the same edge
  always_ff @(posedge clk_i) begin
    if (act) begin
      low_a_rd_q <= low_mem[rc];
      low_b_rd_q <= low_mem[in_col_q];
    end
    if (pix_act) begin
      low_mem[in_col_q] <= pixel_in_i;
    end
  end

  // row two above, filled in the cycle after the input write from the old upper-row entry
  always_ff @(posedge clk_i) begin
    if (act) begin
      high_rd_q <= high_mem[rc];
    end
    if (hw_pend_q) begin
      high_mem[hw_addr_q] <= low_b_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_pend_q <= 1'b0;
    end else begin
      hw_pend_q <= pix_act;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_act) begin
      hw_addr_q <= in_col_q;
      if (in_col_q == '0) begin
        low0_q <= pixel_in_i;
      end
    end
    if (act) begin
      fwd_data_q <= low_b_rd_q;
      s1_q       <= s1_d;
    end
  end

  always_comb begin
    s1_d.emit       = emit;
    s1_d.top_ok     = out_row_q != '0;
    s1_d.bot_ok     = !out_row_end;
    s1_d.left_ok    = out_col_q != '0;
    s1_d.right_ok   = !out_col_end;
    s1_d.last       = out_row_end && out_col_end;
    s1_d.single     = is_pixel && !flushing_q && (h == lap3_pkg::H_W'(1));
    s1_d.fwd        = hw_pend_q && (hw_addr_q == rc);
    s1_d.bot        = is_pixel ? pixel_in_i : '0;
    s1_d.single_mid = (in_col_q == '0) ? pixel_in_i : low0_q;
  end

  always_comb begin
    if (act) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  // new column entering the window
  always_comb begin
    if (s1_q.single) begin
      col_top = '0;
      col_mid = s1_q.single_mid;
      col_bot = '0;
    end else begin
      col_top = s1_q.fwd ? fwd_data_q : high_rd_q;
      col_mid = low_a_rd_q;
      col_bot = s1_q.bot;
    end
  end

  always_comb begin
    for (int dc = 0; dc < 3; dc++) begin
      coef[dc]     = mask_top_q[8*dc +: 8];
      coef[3 + dc] = mask_mid_q[8*dc +: 8];
      coef[6 + dc] = mask_bot_q[8*dc +: 8];
    end
    for (int dr = 0; dr < 3; dr++) begin
      nw[3*dr]     = win_q[3*dr + 1];
      nw[3*dr + 1] = win_q[3*dr + 2];
    end
    nw[2] = col_top;
    nw[5] = col_mid;
    nw[8] = col_bot;
  end

  // weighted sum modulo 256 with the outside positions masked
  always_comb begin
    sum  = '0;
    prod = '0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        prod = nw[3*dr + dc] * coef[3*dr + dc];
        if ((dr != 0 || s1_q.top_ok) && (dr != 2 || s1_q.bot_ok)
            && (dc != 0 || s1_q.left_ok) && (dc != 2 || s1_q.right_ok)) begin
          sum = sum + prod[lap3_pkg::PIX_W-1:0];
        end
      end
    end
  end

  always_comb begin
    if (s1_valid_q && s1_q.emit && s1_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_valid_q && s1_move) begin
        for (int k = 0; k < 9; k++) begin
          win_q[k] <= nw[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_q.emit && s1_move) begin
      pixel_out_q  <= sum;
      frame_last_q <= s1_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pixel_out_q;
  assign frame_last_o = frame_last_q;

  a_in_lin_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !recalc_q |-> in_lin_q == in_calc)
    else $error("input linear position out of step with row and column");

  a_out_lin_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !recalc_q |-> out_lin_q == out_calc)
    else $error("output linear position out of step with row and column");

  a_full_pipe_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && s1_valid_q && s1_q.emit) |-> in_stall_o)
    else $error("item taken while both result stages are full");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q ##1 out_valid_q) |-> $past(s1_valid_q && s1_q.emit))
    else $error("result appeared without an emitting window stage");

endmodule

`default_nettype wire

>>> tb/lap3_checker.sv
// ----------------------------------------------------------------------------
// lap3_checker
// watches the pixel, result and register ports of the 3x3 filter, predicts
// every filtered pixel with its own line rows and window and compares each
// accepted result field by field with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lap3_checker
  import lap3_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 req_type_i,
  input  logic [PIX_W-1:0]     pixel_in_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [PIX_W-1:0]     pixel_out_i,
  input  logic                 frame_last_i,
  output int                   mismatches_o,
  output int                   pending_o,
  output int                   checked_o
);

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic             last;
  } filtered_t;

  filtered_t         due_pixels [$];
  logic [MASK_W-1:0] mask_row [3];
  logic [FW_W-1:0]   width_reg;
  logic [FH_W-1:0]   height_reg;
  logic [PIX_W-1:0]  row_mem [2*MAX_WIDTH];
  logic [PIX_W-1:0]  win [9];
  int unsigned       in_col, in_row, out_col, out_row;
  bit                flushing;

  task automatic report_mismatch(input string what);
    if (mismatches_o < 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches_o++;
  endtask

  // weighted sum at the next centre, zero outside the frame
  function automatic void centre_sum(input int unsigned w, input int unsigned h);
    int unsigned acc;
    filtered_t   res;
    acc = 0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        if ((dr == 0 && out_row < 1) || (dr == 2 && out_row + 1 >= h) ||
            (dc == 0 && out_col < 1) || (dc == 2 && out_col + 1 >= w)) begin
          continue;
        end
        acc += 32'(win[dr*3+dc]) * 32'(mask_row[dr][8*dc +: 8]);
      end
    end
    res.px   = PIX_W'(acc);
    res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
    due_pixels.push_back(res);
    if (res.last) begin
      out_row  = 0;
      out_col  = 0;
      flushing = 1'b0;
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endfunction

  function automatic void filter_step(input logic drain, input logic [PIX_W-1:0] pix);
    int unsigned      w, h, rc;
    logic [PIX_W-1:0] column [3];
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    // a drain with nothing pending is dropped
    if (drain && !flushing) begin
      return;
    end
    if (flushing) begin
      rc = (out_col + 1 >= w) ? 0 : out_col + 1;
    end else begin
      rc = in_col;
    end
    column[0] = (rc < MAX_WIDTH) ? row_mem[MAX_WIDTH + rc] : '0;
    column[1] = (rc < 2*MAX_WIDTH) ? row_mem[rc] : '0;
    column[2] = drain ? '0 : pix;
    if (!drain && in_col < MAX_WIDTH) begin
      row_mem[MAX_WIDTH + in_col] = row_mem[in_col];
      row_mem[in_col]             = pix;
    end
    // single-row frame: next centre needs column 0 of this row
    if (!drain && !flushing && h == 1) begin
      column[0] = '0;
      column[1] = row_mem[0];
      column[2] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
      win[r*3+2] = column[r];
    end
    if (flushing) begin
      centre_sum(w, h);
    end else if (!drain && in_row * w + in_col >= out_row * w + out_col + w + 1) begin
      centre_sum(w, h);
    end
    if (!drain) begin
      if (in_col + 1 >= w) begin
        in_col = 0;
        if (in_row + 1 >= h) begin
          in_row   = 0;
          flushing = 1'b1;
        end else begin
          in_row++;
        end
      end else begin
        in_col++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    filtered_t want;
    if (!rst_ni) begin
      mask_row[0] = MASK_TOP_RST;
      mask_row[1] = MASK_MIDDLE_RST;
      mask_row[2] = MASK_BOTTOM_RST;
      width_reg   = FRAME_W_RST;
      height_reg  = FRAME_H_RST;
      foreach (row_mem[i]) row_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      in_col       = 0;
      in_row       = 0;
      out_col      = 0;
      out_row      = 0;
      flushing     = 1'b0;
      mismatches_o = 0;
      checked_o    = 0;
      due_pixels.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MASK_TOP:     mask_row[0] = cfg_data_i;
          CFG_MASK_MIDDLE:  mask_row[1] = cfg_data_i;
          CFG_MASK_BOTTOM:  mask_row[2] = cfg_data_i;
          CFG_FRAME_WIDTH:  width_reg   = cfg_data_i[FW_W-1:0];
          CFG_FRAME_HEIGHT: height_reg  = cfg_data_i[FH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        filter_step(req_type_i == REQ_DRAIN, pixel_in_i);
      end
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (due_pixels.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", pixel_out_i));
        end else begin
          want = due_pixels.pop_front();
          if (pixel_out_i !== want.px) begin
            report_mismatch($sformatf("pixel_out %0d, expected %0d", pixel_out_i, want.px));
          end
          if (frame_last_i !== want.last) begin
            report_mismatch($sformatf("frame_last %b, expected %b", frame_last_i, want.last));
          end
        end
      end
    end
    pending_o = due_pixels.size();
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives pixel frames, drains and register settings into the 3x3 filter under
// random idling and stalling; the checker beside the block predicts and
// compares every result, this module only makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lap3_pkg::*;

  localparam logic    REQ_PIXEL = ~REQ_DRAIN;
  localparam longint  LIMIT_NS  = 64'd12_000_000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 req_type  = 1'b0;
  logic [PIX_W-1:0]     pixel_in  = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [PIX_W-1:0]     pixel_out;
  logic                 frame_last;

  int          mismatches, pending, checked;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned items_sent, pixels_sent, frames_sent, phases_run;

  laplacian_3x3_convolution u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .req_type_i   (req_type),
    .pixel_in_i   (pixel_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pixel_out_o  (pixel_out),
    .frame_last_o (frame_last)
  );

  lap3_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .req_type_i   (req_type),
    .pixel_in_i   (pixel_in),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .pixel_out_i  (pixel_out),
    .frame_last_i (frame_last),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  initial begin
    #(LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return MASK_W'($urandom);
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic kind, input logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    pixel_in <= pix;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (kind == REQ_PIXEL) begin
      pixels_sent++;
    end
  endtask

  // wait until every predicted result is out, then let the pipe run dry
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_index_e idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input bit with_masks, input logic [MASK_W-1:0] top,
                               input logic [MASK_W-1:0] mid, input logic [MASK_W-1:0] bot,
                               input int unsigned w_reg, input int unsigned h_reg);
    if (with_masks) begin
      cfg_write(CFG_MASK_TOP, top);
      cfg_write(CFG_MASK_MIDDLE, mid);
      cfg_write(CFG_MASK_BOTTOM, bot);
    end
    cfg_write(CFG_FRAME_WIDTH, CFG_W'(w_reg));
    cfg_write(CFG_FRAME_HEIGHT, CFG_W'(h_reg));
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned w_reg, input int unsigned h_reg,
                           input int unsigned frames);
    int unsigned cols, rows;
    cols = (w_reg == 0) ? 1 : ((w_reg > MAX_WIDTH) ? MAX_WIDTH : w_reg);
    rows = (h_reg == 0) ? 1 : ((h_reg > MAX_HEIGHT) ? MAX_HEIGHT : h_reg);
    case (phases_run % 4)
      0: begin
        src_idle_pct = 0;
        sink_stall_pct <= 0;
      end
      1: begin
        src_idle_pct = 65;
        sink_stall_pct <= 0;
      end
      2: begin
        src_idle_pct = 0;
        sink_stall_pct <= 65;
      end
      default: begin
        src_idle_pct = 31;
        sink_stall_pct <= 31;
      end
    endcase
    load_settings(1'b1, pick_mask(), pick_mask(), pick_mask(), w_reg, h_reg);
    for (int unsigned f = 0; f < frames; f++) begin
      for (int unsigned k = 0; k < cols * rows; k++) begin
        // stray drains inside a frame are dropped unless the previous frame still flushes
        if ($urandom_range(99) < 4) begin
          send_item(REQ_DRAIN, pick_pixel());
        end
        send_item(REQ_PIXEL, pick_pixel());
      end
      frames_sent++;
      // partial drain; pixels of the next frame flush the rest
      if (f + 1 < frames) begin
        repeat ($urandom_range(0, cols + 1)) send_item(REQ_DRAIN, pick_pixel());
      end
    end
    repeat (cols + 1) send_item(REQ_DRAIN, pick_pixel());
    settle();
    phases_run++;
  endtask

  initial begin
    logic [PIX_W-1:0] first_frame [6];
    logic [PIX_W-1:0] second_rest [4];
    first_frame = '{8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd128};
    second_rest = '{8'd0, 8'd255, 8'd1, 8'd254};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // reset masks, 3x2 frames
    load_settings(1'b0, '0, '0, '0, 3, 2);
    send_item(REQ_DRAIN, 8'hff);
    foreach (first_frame[i]) send_item(REQ_PIXEL, first_frame[i]);
    // next frame starts while the old one still flushes
    send_item(REQ_PIXEL, 8'hff);
    send_item(REQ_PIXEL, 8'hff);
    repeat (2) send_item(REQ_DRAIN, 8'h00);
    foreach (second_rest[i]) send_item(REQ_PIXEL, second_rest[i]);
    repeat (5) send_item(REQ_DRAIN, 8'h5a);
    settle();
    frames_sent += 2;

    // all coefficients at their top value, single-row frame
    load_settings(1'b1, '1, '1, '1, 3, 1);
    repeat (3) send_item(REQ_PIXEL, 8'hff);
    repeat (3) send_item(REQ_DRAIN, 8'h00);
    settle();
    frames_sent++;
    phases_run = 2;

    while (items_sent < 500) begin
      run_phase(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8),
                ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6),
                $urandom_range(1, 3));
    end

    $display("sent %0d items (%0d pixels) in %0d frames over %0d register settings",
             items_sent, pixels_sent, frames_sent, phases_run);
    $display("compared %0d filtered pixels, %0d mismatches", checked, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/lap3_pkg.sv
rtl/core/laplacian_3x3_convolution.sv
tb/lap3_checker.sv
tb/testbench.sv
